/* design/bounded_ordered_list_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the bounded ordered list engine
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define BOLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bole assertion failed");

// next-cycle implication
`define BOLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bole assertion failed");

`endif

/* design/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg
// Shared codes, widths and the cell control word of the list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 6;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_FIND   = 3'd3;
    localparam logic [2:0] ACT_SIZE   = 3'd4;
    localparam logic [2:0] ACT_DUMP   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_POS   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [POS_W-1:0]    pos;
        logic [LEN_W-1:0]    len;
        logic [WORD_W-1:0]   value;
    } t_cell_ctl;

endpackage

/* design/bole_cell.sv */
// ----------------------------------------------------------------------------
// bole_cell
// One list slot: holds a word and takes it from its neighbours on shifts.
// ----------------------------------------------------------------------------
module bole_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  bole_pkg::t_cell_ctl           i_ctl,
    input  logic [bole_pkg::WORD_W-1:0]   i_left,
    input  logic [bole_pkg::WORD_W-1:0]   i_right,
    input  logic [bole_pkg::WORD_W-1:0]   i_head,
    output logic [bole_pkg::WORD_W-1:0]   o_word
);

    localparam logic [bole_pkg::LEN_W-1:0] C_IDX  = bole_pkg::LEN_W'(IDX);
    localparam logic [bole_pkg::LEN_W-1:0] C_NEXT = bole_pkg::LEN_W'(IDX + 1);

    logic [bole_pkg::WORD_W-1:0] r_word;
    logic [bole_pkg::WORD_W-1:0] n_word;
    logic [bole_pkg::LEN_W-1:0]  w_pos;

    assign w_pos = {1'b0, i_ctl.pos};

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            bole_pkg::CELL_HOLD: begin
                n_word = r_word;
            end
            bole_pkg::CELL_APPEND: begin
                if (C_IDX == i_ctl.len) begin
                    n_word = i_ctl.value;
                end
            end
            bole_pkg::CELL_INSERT: begin
                if (C_IDX == w_pos) begin
                    n_word = i_ctl.value;
                end else if (C_IDX > w_pos && C_IDX <= i_ctl.len) begin
                    n_word = i_left;
                end
            end
            bole_pkg::CELL_DELETE: begin
                if (C_IDX >= w_pos && C_NEXT < i_ctl.len) begin
                    n_word = i_right;
                end
            end
            bole_pkg::CELL_ROTATE: begin
                if (C_NEXT < i_ctl.len) begin
                    n_word = i_right;
                end else if (C_NEXT == i_ctl.len) begin
                    n_word = i_head;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* design/bounded_ordered_list_engine_top.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top: ordered list of signed words in a cell chain
// append, insert, delete, size: result the cycle after acceptance, one request a cycle unless output stalls
// dump: one word a cycle unless output stalls; find: scan then flush state; both hold off new requests
// reset clears length and control only, no clearing pass on the slots
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_top_assert.svh"

module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_action,
    input  logic [bole_pkg::POS_W-1:0]          i_position,
    input  logic signed [bole_pkg::WORD_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_status,
    output logic [bole_pkg::POS_W-1:0]          o_found_position,
    output logic signed [bole_pkg::WORD_W-1:0]  o_word,
    output logic [bole_pkg::LEN_W-1:0]          o_tally,
    output logic                                o_last
);

    localparam int LIMIT = (CAPACITY < bole_pkg::STORE_DEPTH) ?
                           CAPACITY : bole_pkg::STORE_DEPTH;
    localparam logic [bole_pkg::LEN_W-1:0] C_LIMIT = bole_pkg::LEN_W'(LIMIT);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic [bole_pkg::LEN_W-1:0]     r_len, n_len;
    logic [bole_pkg::POS_W-1:0]     r_cnt, n_cnt;
    logic [bole_pkg::LEN_W-1:0]     r_hits, n_hits;
    logic                           r_pend_vld, n_pend_vld;
    logic [bole_pkg::POS_W-1:0]     r_pend_pos, n_pend_pos;
    logic                           r_dump, n_dump;
    logic [bole_pkg::WORD_W-1:0]    r_key, n_key;
    logic                           r_ovalid, n_ovalid;
    logic [2:0]                     r_status, n_status;
    logic [bole_pkg::POS_W-1:0]     r_fpos, n_fpos;
    logic [bole_pkg::WORD_W-1:0]    r_oword, n_oword;
    logic [bole_pkg::LEN_W-1:0]     r_tally, n_tally;
    logic                           r_last, n_last;

    bole_pkg::t_cell_ctl            w_ctl;
    logic [bole_pkg::WORD_W-1:0]    w_word [LIMIT];
    logic [bole_pkg::WORD_W-1:0]    w_head;
    logic                           w_out_free;
    logic                           w_in_acc;
    logic                           w_emit;
    logic                           w_end;
    logic                           w_hit;

    // cell chain
    genvar g;
    generate
        for (g = 0; g < LIMIT; g++) begin : g_cell
            logic [bole_pkg::WORD_W-1:0] w_left;
            logic [bole_pkg::WORD_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_value;
            end else begin : g_mid_l
                assign w_left = w_word[g-1];
            end
            if (g == LIMIT - 1) begin : g_final
                assign w_right = i_value;
            end else begin : g_mid_r
                assign w_right = w_word[g+1];
            end
            bole_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_head),
                .o_word  (w_word[g])
            );
        end
    endgenerate

    assign w_head     = w_word[0];
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_end      = ({1'b0, r_cnt} == (r_len - bole_pkg::LEN_W'(1)));
    assign w_hit      = (w_head == r_key);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_hits     = r_hits;
        n_pend_vld = r_pend_vld;
        n_pend_pos = r_pend_pos;
        n_dump     = r_dump;
        n_key      = r_key;
        w_emit     = 1'b0;
        n_status   = bole_pkg::ST_OK;
        n_fpos     = '0;
        n_oword    = '0;
        n_tally    = r_len;
        n_last     = 1'b1;
        w_ctl.op    = bole_pkg::CELL_HOLD;
        w_ctl.pos   = i_position;
        w_ctl.len   = r_len;
        w_ctl.value = i_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_action)
                        bole_pkg::ACT_APPEND: begin
                            w_emit = 1'b1;
                            if (r_len >= C_LIMIT) begin
                                n_status = bole_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = bole_pkg::CELL_APPEND;
                                n_len    = r_len + bole_pkg::LEN_W'(1);
                                n_tally  = n_len;
                            end
                        end
                        bole_pkg::ACT_INSERT: begin
                            w_emit = 1'b1;
                            if (r_len >= C_LIMIT) begin
                                n_status = bole_pkg::ST_FULL;
                            end else if ({1'b0, i_position} >= r_len) begin
                                n_status = bole_pkg::ST_BAD_POS;
                            end else begin
                                w_ctl.op = bole_pkg::CELL_INSERT;
                                n_len    = r_len + bole_pkg::LEN_W'(1);
                                n_tally  = n_len;
                            end
                        end
                        bole_pkg::ACT_DELETE: begin
                            w_emit = 1'b1;
                            if ({1'b0, i_position} >= r_len) begin
                                n_status = bole_pkg::ST_BAD_POS;
                            end else begin
                                w_ctl.op = bole_pkg::CELL_DELETE;
                                n_len    = r_len - bole_pkg::LEN_W'(1);
                                n_tally  = n_len;
                            end
                        end
                        bole_pkg::ACT_FIND, bole_pkg::ACT_DUMP: begin
                            if (r_len == '0) begin
                                w_emit   = 1'b1;
                                n_tally  = '0;
                                n_status = (i_action == bole_pkg::ACT_FIND) ?
                                           bole_pkg::ST_NOT_FOUND : bole_pkg::ST_EMPTY;
                            end else begin
                                n_state    = S_SCAN;
                                n_cnt      = '0;
                                n_hits     = '0;
                                n_pend_vld = 1'b0;
                                n_dump     = (i_action == bole_pkg::ACT_DUMP);
                                n_key      = i_value;
                            end
                        end
                        bole_pkg::ACT_SIZE: begin
                            w_emit = 1'b1;
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_out_free) begin
                    w_ctl.op = bole_pkg::CELL_ROTATE;
                    n_cnt    = r_cnt + bole_pkg::POS_W'(1);
                    if (r_dump) begin
                        w_emit  = 1'b1;
                        n_fpos  = r_cnt;
                        n_oword = w_head;
                        n_last  = w_end;
                        if (w_end) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        if (w_hit) begin
                            w_emit     = r_pend_vld;
                            n_fpos     = r_pend_pos;
                            n_tally    = r_hits;
                            n_last     = 1'b0;
                            n_pend_vld = 1'b1;
                            n_pend_pos = r_cnt;
                            n_hits     = r_hits + bole_pkg::LEN_W'(1);
                        end
                        if (w_end) begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    n_state    = S_IDLE;
                    n_pend_vld = 1'b0;
                    if (r_pend_vld) begin
                        n_fpos  = r_pend_pos;
                        n_tally = r_hits;
                    end else begin
                        n_status = bole_pkg::ST_NOT_FOUND;
                        n_tally  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = w_emit || (r_ovalid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_cnt      <= '0;
            r_hits     <= '0;
            r_pend_vld <= 1'b0;
            r_dump     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
            r_hits     <= n_hits;
            r_pend_vld <= n_pend_vld;
            r_dump     <= n_dump;
            r_ovalid   <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pend_pos <= n_pend_pos;
        r_key      <= n_key;
        if (w_emit) begin
            r_status <= n_status;
            r_fpos   <= n_fpos;
            r_oword  <= n_oword;
            r_tally  <= n_tally;
            r_last   <= n_last;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_word           = r_oword;
    assign o_tally          = r_tally;
    assign o_last           = r_last;

    `BOLE_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= C_LIMIT)
    `BOLE_ASSERT_IMP(a_scan_idx, i_clk, i_rst_n, r_state == S_SCAN, {1'b0, r_cnt} < r_len)
    `BOLE_ASSERT_NXT(a_scan_len, i_clk, i_rst_n, r_state == S_SCAN, $stable(r_len))
    `BOLE_ASSERT_IMP(a_pend_pos, i_clk, i_rst_n, r_state == S_SCAN && r_pend_vld,
                     r_pend_pos < r_cnt)

endmodule
